// ===== hdl/refcounted_lru_pool_allocator_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the reference-counted LRU pool allocator
// Clocked implication checks with an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef REFCOUNTED_LRU_POOL_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_LRU_POOL_ALLOCATOR_ASSERT_SVH

// Check cons in the same cycle as ante
`define RLPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante
`define RLPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rlpa_pkg.sv =====
// ---------------------------------------------------------------------------
// rlpa_pkg
// Shared constants, codes and record types of the pool allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlpa_pkg;

    // Pool geometry (power-of-two pool, index taken from the low bits)
    localparam int POOL_ENTRIES = 4096;
    localparam int IDX_W        = $clog2(POOL_ENTRIES);
    localparam int LINK_W       = IDX_W + 1;
    localparam int ENTRY_W      = 12;
    localparam int COUNT_BITS   = 8;
    localparam int OUT_COUNT_W  = 8;

    localparam logic [LINK_W-1:0]     NULL_LINK = LINK_W'(POOL_ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(POOL_ENTRIES - 1);

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_ALLOC  = 2'd0,
        FUNC_LOCK   = 2'd1,
        FUNC_UNLOCK = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_EMPTY      = 2'd1,
        STAT_UNLOCK_0   = 2'd2,
        STAT_SATURATED  = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL,
        S_LINK_A,
        S_LINK_B,
        S_DONE
    } state_t;

    // One pool entry as stored in memory
    typedef struct packed {
        logic                  used;
        logic [COUNT_BITS-1:0] count;
        logic [LINK_W-1:0]     prev;
        logic [LINK_W-1:0]     next;
    } entry_t;

    // Per-field write enables
    typedef struct packed {
        logic used;
        logic count;
        logic prev;
        logic next;
    } wr_mask_t;

    // Memory write request
    typedef struct packed {
        wr_mask_t          mask;
        logic [IDX_W-1:0]  addr;
        entry_t            data;
    } mem_wr_t;

    // Pending neighbor link update
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  addr;
        logic              is_next;
        logic [LINK_W-1:0] data;
    } link_wr_t;

    // Result of one item
    typedef struct packed {
        logic [IDX_W-1:0]      entry;
        logic                  was_used;
        logic [COUNT_BITS-1:0] count;
        status_t               status;
    } result_t;

endpackage

// ===== hdl/refcounted_lru_pool_allocator.sv =====
// ---------------------------------------------------------------------------
// refcounted_lru_pool_allocator
// Lock-counted entry pool with a least-recently-freed free list.
// ---------------------------------------------------------------------------
// After reset the block sweeps its pool memory to the initial state, one entry
// a cycle, and accepts no item until the sweep is done. Afterwards each item
// goes through these steps: accept and read the target entry, evaluate and
// rewrite it, patch each neighbor link that changes (none for a query, a
// refused operation or a lock/unlock that keeps the entry off the free list,
// up to two for an unlink), and hand the result to the output register once
// it has room; the pool memory has a single write port. A finished result
// waits in the output register while the next item is taken.
`timescale 1ns / 1ps

module refcounted_lru_pool_allocator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [rlpa_pkg::ENTRY_W-1:0]        entry_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rlpa_pkg::ENTRY_W-1:0]        result_entry,
    output logic                                was_used,
    output logic [rlpa_pkg::OUT_COUNT_W-1:0]    new_count,
    output logic [1:0]                          status
);

    logic                        out_valid_reg, out_valid_next;
    rlpa_pkg::result_t           out_res_reg;
    logic                        out_free;
    logic                        res_valid;
    rlpa_pkg::result_t           res;
    logic                        rd_en;
    logic [rlpa_pkg::IDX_W-1:0]  rd_addr;
    rlpa_pkg::entry_t            rd_data;
    rlpa_pkg::mem_wr_t           wr;

    assign out_free = !out_valid_reg || out_ready;

    rlpa_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .entry_index (entry_index),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr          (wr)
    );

    rlpa_pool_mem u_mem
    (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_entry = rlpa_pkg::ENTRY_W'(out_res_reg.entry);
    assign was_used     = out_res_reg.was_used;
    assign new_count    = out_res_reg.count[rlpa_pkg::OUT_COUNT_W-1:0];
    assign status       = out_res_reg.status;

endmodule

// ===== hdl/rlpa_pool_mem.sv =====
// ---------------------------------------------------------------------------
// rlpa_pool_mem
// Pool entry memory: one write port with per-field enables, one registered
// read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlpa_pool_mem
(
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [rlpa_pkg::IDX_W-1:0]   rd_addr,
    output rlpa_pkg::entry_t             rd_data,
    input  rlpa_pkg::mem_wr_t            wr
);

    logic                            used_mem  [rlpa_pkg::POOL_ENTRIES];
    logic [rlpa_pkg::COUNT_BITS-1:0] count_mem [rlpa_pkg::POOL_ENTRIES];
    logic [rlpa_pkg::LINK_W-1:0]     prev_mem  [rlpa_pkg::POOL_ENTRIES];
    logic [rlpa_pkg::LINK_W-1:0]     next_mem  [rlpa_pkg::POOL_ENTRIES];

    rlpa_pkg::entry_t rd_data_reg;

    // Write enabled fields
    always_ff @(posedge clk)
    begin
        if (wr.mask.used)
        begin
            used_mem[wr.addr] <= wr.data.used;
        end
        if (wr.mask.count)
        begin
            count_mem[wr.addr] <= wr.data.count;
        end
        if (wr.mask.prev)
        begin
            prev_mem[wr.addr] <= wr.data.prev;
        end
        if (wr.mask.next)
        begin
            next_mem[wr.addr] <= wr.data.next;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg.used  <= used_mem[rd_addr];
            rd_data_reg.count <= count_mem[rd_addr];
            rd_data_reg.prev  <= prev_mem[rd_addr];
            rd_data_reg.next  <= next_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/rlpa_ctrl.sv =====
// ---------------------------------------------------------------------------
// rlpa_ctrl
// Sequencer: clears the pool after reset, then per item reads the target
// entry, rewrites it and patches up to two neighbor links.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "refcounted_lru_pool_allocator_assert.svh"

module rlpa_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    func,
    input  logic [rlpa_pkg::ENTRY_W-1:0]  entry_index,
    input  logic                          out_free,
    output logic                          res_valid,
    output rlpa_pkg::result_t             res,
    output logic                          rd_en,
    output logic [rlpa_pkg::IDX_W-1:0]    rd_addr,
    input  rlpa_pkg::entry_t              rd_data,
    output rlpa_pkg::mem_wr_t             wr
);

    rlpa_pkg::state_t            state_reg,   state_next;
    logic [rlpa_pkg::IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [rlpa_pkg::LINK_W-1:0] head_reg,    head_next;
    logic [rlpa_pkg::LINK_W-1:0] tail_reg,    tail_next;
    rlpa_pkg::func_t             func_reg,    func_next;
    logic [rlpa_pkg::IDX_W-1:0]  tgt_reg,     tgt_next;
    rlpa_pkg::result_t           res_reg,     res_next;
    rlpa_pkg::link_wr_t          link_a_reg,  link_a_next;
    rlpa_pkg::link_wr_t          link_b_reg,  link_b_next;

    logic                            accept;
    logic [rlpa_pkg::IDX_W-1:0]      in_idx;
    logic [rlpa_pkg::COUNT_BITS-1:0] new_cnt;
    logic                            do_unlink;

    assign in_idx = entry_index[rlpa_pkg::IDX_W-1:0];
    assign accept = in_valid && in_ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rlpa_pkg::S_CLEAR;
            clr_idx_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= rlpa_pkg::LINK_W'(rlpa_pkg::LAST_IDX);
            link_a_reg  <= '0;
            link_b_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            link_a_reg  <= link_a_next;
            link_b_reg  <= link_b_next;
        end
    end

    // Item payload registers
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        tgt_reg  <= tgt_next;
        res_reg  <= res_next;
    end

    // Next state, memory requests and result
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        func_next    = func_reg;
        tgt_next     = tgt_reg;
        res_next     = res_reg;
        link_a_next  = link_a_reg;
        link_b_next  = link_b_reg;
        in_ready     = 1'b0;
        res_valid    = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = in_idx;
        wr           = '0;
        new_cnt      = rd_data.count;
        do_unlink    = 1'b0;

        unique case (state_reg)
            rlpa_pkg::S_CLEAR:
            begin
                // Sweep reset values into the pool, one entry a cycle
                wr.mask       = '1;
                wr.addr       = clr_idx_reg;
                wr.data.used  = 1'b0;
                wr.data.count = '0;
                wr.data.prev  = (clr_idx_reg == '0) ? rlpa_pkg::NULL_LINK
                              : rlpa_pkg::LINK_W'(clr_idx_reg) - rlpa_pkg::LINK_W'(1);
                wr.data.next  = (clr_idx_reg == rlpa_pkg::LAST_IDX) ? rlpa_pkg::NULL_LINK
                              : rlpa_pkg::LINK_W'(clr_idx_reg) + rlpa_pkg::LINK_W'(1);
                clr_idx_next  = clr_idx_reg + rlpa_pkg::IDX_W'(1);
                if (clr_idx_reg == rlpa_pkg::LAST_IDX)
                begin
                    state_next = rlpa_pkg::S_IDLE;
                end
            end

            rlpa_pkg::S_IDLE:
            begin
                // Take an item and start the read of its target entry
                in_ready = 1'b1;
                if (rlpa_pkg::func_t'(func) == rlpa_pkg::FUNC_ALLOC)
                begin
                    rd_addr = head_reg[rlpa_pkg::IDX_W-1:0];
                end
                if (accept)
                begin
                    rd_en      = 1'b1;
                    func_next  = rlpa_pkg::func_t'(func);
                    tgt_next   = rd_addr;
                    state_next = rlpa_pkg::S_EVAL;
                end
            end

            rlpa_pkg::S_EVAL:
            begin
                res_next.entry    = tgt_reg;
                res_next.was_used = 1'b0;
                res_next.count    = rd_data.count;
                res_next.status   = rlpa_pkg::STAT_OK;
                link_a_next       = '0;
                link_b_next       = '0;
                wr.addr           = tgt_reg;
                wr.data           = rd_data;

                case (func_reg)
                    rlpa_pkg::FUNC_ALLOC:
                    begin
                        if (head_reg == rlpa_pkg::NULL_LINK)
                        begin
                            res_next.entry  = '0;
                            res_next.count  = '0;
                            res_next.status = rlpa_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            do_unlink = (rd_data.count == '0);
                            if (rd_data.count < rlpa_pkg::COUNT_MAX)
                            begin
                                new_cnt = rd_data.count + rlpa_pkg::COUNT_BITS'(1);
                            end
                            res_next.was_used = rd_data.used;
                            res_next.count    = new_cnt;
                            wr.mask.used      = 1'b1;
                            wr.mask.count     = 1'b1;
                            wr.data.used      = 1'b1;
                            wr.data.count     = new_cnt;
                        end
                    end

                    rlpa_pkg::FUNC_LOCK:
                    begin
                        if (rd_data.count == rlpa_pkg::COUNT_MAX)
                        begin
                            res_next.status = rlpa_pkg::STAT_SATURATED;
                        end
                        else
                        begin
                            do_unlink      = (rd_data.count == '0);
                            new_cnt        = rd_data.count + rlpa_pkg::COUNT_BITS'(1);
                            res_next.count = new_cnt;
                            wr.mask.count  = 1'b1;
                            wr.data.count  = new_cnt;
                        end
                    end

                    rlpa_pkg::FUNC_UNLOCK:
                    begin
                        if (rd_data.count == '0)
                        begin
                            res_next.status = rlpa_pkg::STAT_UNLOCK_0;
                        end
                        else
                        begin
                            new_cnt        = rd_data.count - rlpa_pkg::COUNT_BITS'(1);
                            res_next.count = new_cnt;
                            wr.mask.count  = 1'b1;
                            wr.data.count  = new_cnt;
                            // Append at the tail when the last lock drops
                            if (new_cnt == '0)
                            begin
                                wr.mask.prev = 1'b1;
                                wr.mask.next = 1'b1;
                                wr.data.prev = tail_reg;
                                wr.data.next = rlpa_pkg::NULL_LINK;
                                if (tail_reg != rlpa_pkg::NULL_LINK)
                                begin
                                    link_a_next.valid   = 1'b1;
                                    link_a_next.addr    = tail_reg[rlpa_pkg::IDX_W-1:0];
                                    link_a_next.is_next = 1'b1;
                                    link_a_next.data    = rlpa_pkg::LINK_W'(tgt_reg);
                                end
                                else
                                begin
                                    head_next = rlpa_pkg::LINK_W'(tgt_reg);
                                end
                                tail_next = rlpa_pkg::LINK_W'(tgt_reg);
                            end
                        end
                    end

                    default:
                    begin
                        // Query: report the count, change nothing
                    end
                endcase

                // Unlink the target from the free list
                if (do_unlink)
                begin
                    if (rd_data.prev != rlpa_pkg::NULL_LINK)
                    begin
                        link_a_next.valid   = 1'b1;
                        link_a_next.addr    = rd_data.prev[rlpa_pkg::IDX_W-1:0];
                        link_a_next.is_next = 1'b1;
                        link_a_next.data    = rd_data.next;
                    end
                    else
                    begin
                        head_next = rd_data.next;
                    end
                    if (rd_data.next != rlpa_pkg::NULL_LINK)
                    begin
                        link_b_next.valid   = 1'b1;
                        link_b_next.addr    = rd_data.next[rlpa_pkg::IDX_W-1:0];
                        link_b_next.is_next = 1'b0;
                        link_b_next.data    = rd_data.prev;
                    end
                    else
                    begin
                        tail_next = rd_data.prev;
                    end
                end

                if (link_a_next.valid)
                begin
                    state_next = rlpa_pkg::S_LINK_A;
                end
                else if (link_b_next.valid)
                begin
                    state_next = rlpa_pkg::S_LINK_B;
                end
                else
                begin
                    state_next = rlpa_pkg::S_DONE;
                end
            end

            rlpa_pkg::S_LINK_A:
            begin
                // Patch the first neighbor link
                wr.addr      = link_a_reg.addr;
                wr.mask.next = link_a_reg.is_next;
                wr.mask.prev = !link_a_reg.is_next;
                wr.data.next = link_a_reg.data;
                wr.data.prev = link_a_reg.data;
                state_next   = link_b_reg.valid ? rlpa_pkg::S_LINK_B : rlpa_pkg::S_DONE;
            end

            rlpa_pkg::S_LINK_B:
            begin
                // Patch the second neighbor link
                wr.addr      = link_b_reg.addr;
                wr.mask.next = link_b_reg.is_next;
                wr.mask.prev = !link_b_reg.is_next;
                wr.data.next = link_b_reg.data;
                wr.data.prev = link_b_reg.data;
                state_next   = rlpa_pkg::S_DONE;
            end

            rlpa_pkg::S_DONE:
            begin
                // Hand the result over once the output register has room
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = rlpa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rlpa_pkg::S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    // Checks
    `RLPA_ASSERT_SAME(a_no_write_idle, clk, rst_n, state_reg == rlpa_pkg::S_IDLE, wr.mask == '0, "pool written while idle")
    `RLPA_ASSERT_NEXT(a_accept_eval, clk, rst_n, accept, state_reg == rlpa_pkg::S_EVAL, "accepted item did not reach evaluation")
    `RLPA_ASSERT_SAME(a_list_ends, clk, rst_n, 1'b1, (head_reg == rlpa_pkg::NULL_LINK) == (tail_reg == rlpa_pkg::NULL_LINK), "free list head and tail disagree on empty")
    `RLPA_ASSERT_SAME(a_links_differ, clk, rst_n, link_a_reg.valid && link_b_reg.valid && state_reg == rlpa_pkg::S_LINK_A, link_a_reg.addr != link_b_reg.addr, "both link writes hit one entry")

endmodule
